// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file lfps_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock out of reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent on the next clock
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// checked during reset as well
`define ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/lfps_pkg.sv -----
`default_nettype none
package lfps_pkg;

  localparam logic [1:0] CFG_PROP_GAIN   = 2'd0;
  localparam logic [1:0] CFG_DERIV_GAIN  = 2'd1;
  localparam logic [1:0] CFG_STEER_LIMIT = 2'd2;
  localparam logic [1:0] CFG_WHEEL_LIMIT = 2'd3;

  localparam logic [9:0]  PROP_GAIN_RST   = 10'd120;
  localparam logic [11:0] DERIV_GAIN_RST  = 12'd600;
  localparam logic [10:0] STEER_LIMIT_RST = 11'd1000;
  localparam logic [11:0] WHEEL_LIMIT_RST = 12'd2000;

  localparam logic [1:0] DEBOUNCE_REPEATS = 2'd2;

  localparam logic signed [17:0] STEER_MAX = 18'sd1023;
  localparam logic signed [17:0] STEER_MIN = -18'sd1024;
  localparam logic signed [12:0] WHEEL_MAX = 13'sd2047;
  localparam logic signed [12:0] WHEEL_MIN = -13'sd2048;

  typedef struct packed {
    logic signed [3:0] err;
    logic signed [4:0] diff;
  } pd_in_t;

  typedef struct packed {
    logic              known;
    logic signed [3:0] err;
  } pat_err_t;

  function automatic pat_err_t pattern_error(input logic [7:0] pat);
    pat_err_t r;
    r.known = 1'b1;
    case (pat) inside
      8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd125: r.err = -4'sd6;
      8'd2, 8'd6, 8'd14, 8'd30, 8'd62:               r.err = -4'sd4;
      8'd4, 8'd12, 8'd28:                            r.err = -4'sd2;
      8'd8, 8'd16:                                   r.err = 4'sd1;
      8'd32, 8'd48, 8'd56:                           r.err = 4'sd2;
      8'd64, 8'd96, 8'd120, 8'd124:                  r.err = 4'sd4;
      8'd128, 8'd160, 8'd192, 8'd224, 8'd240, 8'd248, 8'd252, 8'd254:
                                                     r.err = 4'sd6;
      8'd0, 8'd24, 8'd60, 8'd126:                    r.err = 4'sd0;
      default: begin
        r.known = 1'b0;
        r.err   = 4'sd0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lfps_track.sv -----
`default_nettype none
module lfps_track
  import lfps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] pattern,
  input  wire logic       clear_history,
  output pd_in_t          pd_in
);

  logic [7:0]        prev_pattern, prev_pattern_next;
  logic [1:0]        same_count, same_count_next;
  logic signed [3:0] held_error, held_error_next;
  logic signed [3:0] prev_error, prev_eff;
  logic [1:0]        cnt_step;
  pat_err_t          lookup;
  logic signed [4:0] err5, half_sum;

  always_comb begin
    lookup            = pattern_error(pattern);
    prev_pattern_next = pattern;
    held_error_next   = held_error;
    if (pattern == prev_pattern) begin
      cnt_step = same_count + 2'd1;
    end else begin
      cnt_step = 2'd0;
    end
    same_count_next = cnt_step;
    if (cnt_step >= DEBOUNCE_REPEATS) begin
      if (lookup.known) begin
        held_error_next = lookup.err;
      end
      same_count_next = 2'd0;
    end

    prev_eff = clear_history ? 4'sd0 : prev_error;
    err5     = {held_error_next[3], held_error_next};
    half_sum = err5 + {4'b0, held_error_next[3]};
    pd_in.err = held_error_next;
    if (prev_eff == 4'sd0 && held_error_next != 4'sd0) begin
      pd_in.diff = {half_sum[4], half_sum[4:1]};
    end else begin
      pd_in.diff = err5 - {prev_eff[3], prev_eff};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pattern <= '0;
      same_count   <= '0;
      held_error   <= '0;
      prev_error   <= '0;
    end else if (advance) begin
      prev_pattern <= prev_pattern_next;
      same_count   <= same_count_next;
      held_error   <= held_error_next;
      prev_error   <= held_error_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lfps_mix.sv -----
`default_nettype none
module lfps_mix
  import lfps_pkg::*;
(
  input  wire pd_in_t             pd_in,
  input  wire logic        [9:0]  prop_gain,
  input  wire logic        [11:0] deriv_gain,
  input  wire logic        [10:0] steer_limit,
  input  wire logic        [11:0] wheel_limit,
  input  wire logic signed [11:0] cruise_speed,
  output logic signed      [10:0] steer_value,
  output logic signed      [11:0] left_wheel,
  output logic signed      [11:0] right_wheel
);

  logic signed [17:0] p_term, d_term, sum, sl, s1, s2;
  logic signed [12:0] wl, base13, steer13, left13, right13, l1, r1, l2, r2;

  always_comb begin
    p_term = $signed({8'b0, prop_gain}) * $signed({{14{pd_in.err[3]}}, pd_in.err});
    d_term = $signed({6'b0, deriv_gain}) * $signed({{13{pd_in.diff[4]}}, pd_in.diff});
    sum    = p_term + d_term;
    sl     = $signed({7'b0, steer_limit});

    if (sum > sl) begin
      s1 = sl;
    end else if (sum < -sl) begin
      s1 = -sl;
    end else begin
      s1 = sum;
    end
    if (s1 > STEER_MAX) begin
      s2 = STEER_MAX;
    end else if (s1 < STEER_MIN) begin
      s2 = STEER_MIN;
    end else begin
      s2 = s1;
    end
    steer_value = s2[10:0];

    wl      = $signed({1'b0, wheel_limit});
    base13  = {cruise_speed[11], cruise_speed};
    steer13 = {{2{s2[10]}}, s2[10:0]};
    left13  = base13 - steer13;
    right13 = base13 + steer13;

    if (left13 > wl) begin
      l1 = wl;
    end else if (left13 < -wl) begin
      l1 = -wl;
    end else begin
      l1 = left13;
    end
    if (right13 > wl) begin
      r1 = wl;
    end else if (right13 < -wl) begin
      r1 = -wl;
    end else begin
      r1 = right13;
    end

    if (l1 > WHEEL_MAX) begin
      l2 = WHEEL_MAX;
    end else if (l1 < WHEEL_MIN) begin
      l2 = WHEEL_MIN;
    end else begin
      l2 = l1;
    end
    if (r1 > WHEEL_MAX) begin
      r2 = WHEEL_MAX;
    end else if (r1 < WHEEL_MIN) begin
      r2 = WHEEL_MIN;
    end else begin
      r2 = r1;
    end
    left_wheel  = l2[11:0];
    right_wheel = r2[11:0];
  end

endmodule
`default_nettype wire

// ----- rtl/line_follow_pd_steering_top.sv -----
// an accepted input waits in the input register; out_valid rises when the result register loads it
// throughput: one item per cycle unless stalled; one compute pass from input to result register
// out_stall holds the result register and backs up into in_stall only when the input register is full
// reset (rst, synchronous): pipeline empty, debounce and error history zero, gains and limits to defaults
`default_nettype none
module line_follow_pd_steering_top
  import lfps_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [7:0]  sensor_pattern,
  input  wire logic signed [11:0] cruise_speed,
  input  wire logic               clear_history,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [3:0]  track_error,
  output logic signed      [10:0] steer_value,
  output logic signed      [11:0] left_wheel,
  output logic signed      [11:0] right_wheel,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [11:0] cfg_data
);

  logic              in_full;
  logic [7:0]        pat_r;
  logic signed [11:0] base_r;
  logic              clr_r;
  logic              move;
  logic              in_take;
  logic [9:0]        prop_gain;
  logic [11:0]       deriv_gain;
  logic [10:0]       steer_limit;
  logic [11:0]       wheel_limit;
  pd_in_t            pd_in;
  logic signed [10:0] steer_c;
  logic signed [11:0] left_c, right_c;

  assign cfg_ready = 1'b1;
  assign move      = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !move;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= PROP_GAIN_RST;
      deriv_gain  <= DERIV_GAIN_RST;
      steer_limit <= STEER_LIMIT_RST;
      wheel_limit <= WHEEL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:   prop_gain   <= cfg_data[9:0];
        CFG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        CFG_STEER_LIMIT: steer_limit <= cfg_data[10:0];
        CFG_WHEEL_LIMIT: wheel_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pat_r  <= sensor_pattern;
      base_r <= cruise_speed;
      clr_r  <= clear_history;
    end
  end

  lfps_track u_track (
    .clk           (clk),
    .rst           (rst),
    .advance       (move),
    .pattern       (pat_r),
    .clear_history (clr_r),
    .pd_in         (pd_in)
  );

  lfps_mix u_mix (
    .pd_in        (pd_in),
    .prop_gain    (prop_gain),
    .deriv_gain   (deriv_gain),
    .steer_limit  (steer_limit),
    .wheel_limit  (wheel_limit),
    .cruise_speed (base_r),
    .steer_value  (steer_c),
    .left_wheel   (left_c),
    .right_wheel  (right_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      track_error <= pd_in.err;
      steer_value <= steer_c;
      left_wheel  <= left_c;
      right_wheel <= right_c;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lfps_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module lfps_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [3:0]  track_error,
  input wire logic signed [10:0] steer_value,
  input wire logic signed [11:0] left_wheel,
  input wire logic signed [11:0] right_wheel
);

  logic err_ok;
  logic zero_ok;

  assign err_ok  = track_error >= -4'sd6 && track_error <= 4'sd6;
  assign zero_ok = steer_value != 11'sd0 || left_wheel == right_wheel;

  `ASSERT_RESET(a_reset_empty, rst, !out_valid, "result valid right after reset")
  `ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "stalled result dropped")
  `ASSERT_ALWAYS(a_err_range, !out_valid || err_ok, "tracking error out of range")
  `ASSERT_ALWAYS(a_zero_steer, !out_valid || zero_ok, "wheels differ with zero steering")

endmodule

bind line_follow_pd_steering_top lfps_checker u_lfps_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .track_error (track_error),
  .steer_value (steer_value),
  .left_wheel  (left_wheel),
  .right_wheel (right_wheel)
);
`default_nettype wire
